FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the binomial coefficient unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off during reset
`define BCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset
`define BCU_ASSERT_NEVER(lbl, cond, msg) \
  `BCU_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/bcu_pkg.sv
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared types and constants of the binomial coefficient unit.
// ----------------------------------------------------------------------------
package bcu_pkg;

  // Operand and result widths
  localparam int unsigned NW       = 10;
  localparam int unsigned AccW     = 63;
  localparam int unsigned MulW     = AccW + NW;
  // Dividend padded to an even width for two quotient bits per cycle
  localparam int unsigned ProdW    = MulW + (MulW % 2);
  localparam int unsigned DivIters = ProdW / 2;
  localparam int unsigned DivCntW  = $clog2(DivIters);

  // Largest accepted n
  localparam int unsigned MaxN = 1023;

  // Saturation value of the result
  localparam logic [AccW-1:0] ResultLimit = {AccW{1'b1}};

  // Controller states
  typedef enum logic [2:0] {
    StIdle,
    StLoop,
    StDiv,
    StCheck,
    StFinish
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch a new request
    logic mul;    // start a step: multiply and bump the step count
    logic div;    // one radix-4 division cycle
    logic check;  // take the quotient, flag overflow
    logic emit;   // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;         // k above n, or n above the limit
    logic steps_done;  // all steps taken
    logic ovf;         // partial value passed the limit
    logic div_last;    // final division cycle
  } sts_t;

endpackage

FILE: src/binomial_coefficient_unit.sv
// ----------------------------------------------------------------------------
// binomial_coefficient_unit
// Computes C(n,k) for 10-bit n and k; saturates to 2^63-1 with an overflow
// flag when the value leaves the signed 64-bit range. k above n gives 0, k of
// zero gives 1. One request is worked at a time. The value is built as
// C(n-kk+i, i) for i = 1..kk with kk = min(k, n-k); each step runs a multiply,
// the radix-4 exact divider and a check, and request and result handling
// come around the steps. The steps run never exceed 34, because larger
// values overflow and stop early.
// A new request is taken while the previous result still waits on its output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binomial_coefficient_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [bcu_pkg::NW-1:0]   set_size_i,
  input  logic [bcu_pkg::NW-1:0]   choose_count_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [bcu_pkg::AccW-1:0] combinations_o,
  output logic                     overflow_o
);

  bcu_pkg::cmd_t cmd;
  bcu_pkg::sts_t sts;

  // Sequencer
  bcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic
  bcu_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .set_size_i     (set_size_i),
    .choose_count_i (choose_count_i),
    .combinations_o (combinations_o),
    .overflow_o     (overflow_o)
  );

  // Checks
  `BCU_ASSERT(a_busy_after_req, (in_valid_i && !in_stall_o) |=> in_stall_o, "request not held off")
  `BCU_ASSERT(a_ovf_saturates, (out_valid_o && overflow_o) |-> (combinations_o == bcu_pkg::ResultLimit), "overflow without saturation")
  `BCU_ASSERT_NEVER(a_cmd_onehot, !$onehot0(cmd), "conflicting datapath commands")

endmodule

FILE: src/bcu_ctrl.sv
// ----------------------------------------------------------------------------
// bcu_ctrl
// Sequencer for the binomial coefficient unit: handshakes and step control.
// ----------------------------------------------------------------------------
module bcu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  bcu_pkg::sts_t sts_i,
  output bcu_pkg::cmd_t cmd_o
);

  bcu_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcu_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      bcu_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bcu_pkg::StLoop;
        end
      end
      bcu_pkg::StLoop: begin
        if (sts_i.bad || sts_i.ovf || sts_i.steps_done) begin
          state_d = bcu_pkg::StFinish;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = bcu_pkg::StDiv;
        end
      end
      bcu_pkg::StDiv: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = bcu_pkg::StCheck;
        end
      end
      bcu_pkg::StCheck: begin
        cmd_o.check = 1'b1;
        state_d     = bcu_pkg::StLoop;
      end
      bcu_pkg::StFinish: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = bcu_pkg::StIdle;
        end
      end
      default: begin
        state_d = bcu_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/bcu_dp.sv
// ----------------------------------------------------------------------------
// bcu_dp
// Datapath: running coefficient, 63x10 multiplier, radix-4 exact divider.
// ----------------------------------------------------------------------------
module bcu_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bcu_pkg::cmd_t               cmd_i,
  output bcu_pkg::sts_t               sts_o,
  input  logic [bcu_pkg::NW-1:0]      set_size_i,
  input  logic [bcu_pkg::NW-1:0]      choose_count_i,
  output logic [bcu_pkg::AccW-1:0]    combinations_o,
  output logic                        overflow_o
);

  logic [bcu_pkg::NW-1:0]      kk_q, base_q, step_q, div_q, rem_q;
  logic                        bad_q, ovf_q;
  logic [bcu_pkg::AccW-1:0]    acc_q;
  logic [bcu_pkg::ProdW-1:0]   prod_q;
  logic [bcu_pkg::DivCntW-1:0] cnt_q;
  logic [bcu_pkg::AccW-1:0]    comb_q;
  logic                        ovf_out_q;

  logic                        bad_in;
  logic [bcu_pkg::NW-1:0]      diff_in, kk_in, step_nxt, mult;
  logic [bcu_pkg::MulW-1:0]    mul_res;
  logic [bcu_pkg::NW:0]        t1, t2, s1, s2;
  logic                        q1, q2;
  logic [bcu_pkg::NW-1:0]      r1, r2;

  // Request decode: k above n is rejected, otherwise use min(k, n-k)
  assign bad_in  = (choose_count_i > set_size_i) || (32'(set_size_i) > bcu_pkg::MaxN);
  assign diff_in = set_size_i - choose_count_i;
  assign kk_in   = (diff_in < choose_count_i) ? diff_in : choose_count_i;

  // Step i multiplies by (n - kk + i)
  assign step_nxt = step_q + 1'b1;
  assign mult     = base_q + step_nxt;
  assign mul_res  = acc_q * mult;

  // Two restoring division steps per cycle
  assign t1 = {rem_q, prod_q[bcu_pkg::ProdW-1]};
  assign s1 = t1 - {1'b0, div_q};
  assign q1 = (t1 >= {1'b0, div_q});
  assign r1 = q1 ? s1[bcu_pkg::NW-1:0] : t1[bcu_pkg::NW-1:0];
  assign t2 = {r1, prod_q[bcu_pkg::ProdW-2]};
  assign s2 = t2 - {1'b0, div_q};
  assign q2 = (t2 >= {1'b0, div_q});
  assign r2 = q2 ? s2[bcu_pkg::NW-1:0] : t2[bcu_pkg::NW-1:0];

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q  <= 1'b0;
      ovf_q  <= 1'b0;
      step_q <= '0;
      kk_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        bad_q  <= bad_in;
        ovf_q  <= 1'b0;
        step_q <= '0;
        kk_q   <= kk_in;
      end
      if (cmd_i.mul) begin
        step_q <= step_nxt;
        cnt_q  <= '0;
      end
      if (cmd_i.div) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.check && (prod_q[bcu_pkg::ProdW-1:bcu_pkg::AccW] != '0)) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= set_size_i - kk_in;
      acc_q  <= bcu_pkg::AccW'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= bcu_pkg::ProdW'(mul_res);
      div_q  <= step_nxt;
      rem_q  <= '0;
    end
    if (cmd_i.div) begin
      prod_q <= {prod_q[bcu_pkg::ProdW-3:0], q1, q2};
      rem_q  <= r2;
    end
    if (cmd_i.check) begin
      acc_q <= prod_q[bcu_pkg::AccW-1:0];
    end
    if (cmd_i.emit) begin
      if (bad_q) begin
        comb_q    <= '0;
        ovf_out_q <= 1'b0;
      end else if (ovf_q) begin
        comb_q    <= bcu_pkg::ResultLimit;
        ovf_out_q <= 1'b1;
      end else begin
        comb_q    <= acc_q;
        ovf_out_q <= 1'b0;
      end
    end
  end

  assign sts_o.bad        = bad_q;
  assign sts_o.ovf        = ovf_q;
  assign sts_o.steps_done = (step_q == kk_q);
  assign sts_o.div_last   = (cnt_q == bcu_pkg::DivCntW'(bcu_pkg::DivIters - 1));

  assign combinations_o = comb_q;
  assign overflow_o     = ovf_out_q;

endmodule
